[src/teq_pkg.sv]
// Package for the time-ordered event queue.
// Holds the request codes, status codes, sequencer states and default sizes.
// No dependencies.
package teq_pkg;

    localparam int SLOTS_DEF       = 64;
    localparam int ACTOR_BITS_DEF  = 8;
    localparam int EFFECT_BITS_DEF = 6;
    localparam int TIME_BITS       = 31;
    localparam int DELAY_BITS      = 16;
    localparam int FUNC_BITS       = 3;
    localparam int STATUS_BITS     = 2;

    localparam logic [TIME_BITS-1:0] TIME_MAX        = '1;
    localparam logic [TIME_BITS-1:0] THRESHOLD_RESET = 31'd1000000000;

    // Request codes.
    localparam logic [FUNC_BITS-1:0] FN_INS_ACTOR  = 3'd0;
    localparam logic [FUNC_BITS-1:0] FN_INS_EFFECT = 3'd1;
    localparam logic [FUNC_BITS-1:0] FN_REM_ACTOR  = 3'd2;
    localparam logic [FUNC_BITS-1:0] FN_REM_EFFECT = 3'd3;
    localparam logic [FUNC_BITS-1:0] FN_POP        = 3'd4;

    // Status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_IHEAD,
        S_IWALK,
        S_LINK1,
        S_LINK2,
        S_RHEAD,
        S_RWALK,
        S_POP,
        S_REBASE
    } state_t;

endpackage

[src/teq_if.sv]
// Channel interfaces of the event queue: request, response and configuration.
// Depends on teq_pkg.
interface teq_req_if import teq_pkg::*; #(
    parameter int ACTOR_BITS  = ACTOR_BITS_DEF,
    parameter int EFFECT_BITS = EFFECT_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [FUNC_BITS-1:0]   func;
    logic [ACTOR_BITS-1:0]  actor_id;
    logic [EFFECT_BITS-1:0] effect_id;
    logic [DELAY_BITS-1:0]  delay;

    modport source (output valid, func, actor_id, effect_id, delay, input ready);
    modport sink (input valid, func, actor_id, effect_id, delay, output ready);
endinterface

interface teq_rsp_if import teq_pkg::*; #(
    parameter int ACTOR_BITS  = ACTOR_BITS_DEF,
    parameter int EFFECT_BITS = EFFECT_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic                   popped_is_actor;
    logic [ACTOR_BITS-1:0]  popped_actor;
    logic [EFFECT_BITS-1:0] popped_effect;
    logic [TIME_BITS-1:0]   popped_time;

    modport source (output valid, status, popped_is_actor, popped_actor, popped_effect,
                    popped_time, input ready);
    modport sink (input valid, status, popped_is_actor, popped_actor, popped_effect,
                  popped_time, output ready);
endinterface

interface teq_cfg_if import teq_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[src/time_ordered_event_queue_top.sv]
// Time-ordered event queue: entries live in slot RAMs linked in time order, free slots on
// a stack RAM. One request at a time; the slot memory's single read port sets the pace.
// Insert takes a slot and writes the entry, which becomes the head of an empty queue;
// otherwise it goes in front of the head or walks past every entry whose time is not
// later and is linked in behind the last one passed. Remove walks from the head until an
// entry matches or the list ends. Pop unlinks the head, and when the popped time exceeds
// the threshold all stored times are rebased. Requests that end at once (empty, full,
// unknown code) are answered straight from idle.
// Depends on teq_pkg, teq_if and teq_ram.
module time_ordered_event_queue_top import teq_pkg::*; #(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int ACTOR_BITS  = ACTOR_BITS_DEF,
    parameter int EFFECT_BITS = EFFECT_BITS_DEF
) (
    input logic      clk,
    input logic      rst_n,
    teq_req_if.sink  req,
    teq_rsp_if.source rsp,
    teq_cfg_if.sink  cfg
);
    localparam int AW  = $clog2(SLOTS);
    localparam int PW  = $clog2(SLOTS + 1);
    localparam int PLW = 1 + ACTOR_BITS + EFFECT_BITS;
    localparam logic [PW-1:0] NIL  = PW'(SLOTS);
    localparam logic [PW-1:0] LAST = PW'(SLOTS - 1);

    state_t state_reg, state_next;

    logic [FUNC_BITS-1:0]   func_reg, func_next;
    logic [ACTOR_BITS-1:0]  actor_reg, actor_next;
    logic [EFFECT_BITS-1:0] effect_reg, effect_next;
    logic [TIME_BITS-1:0]   t_reg, t_next;
    logic [TIME_BITS-1:0]   start_reg, start_next;
    logic [TIME_BITS-1:0]   thr_reg;
    logic [PW-1:0]          head_reg, head_next;
    logic [PW-1:0]          count_reg, count_next;
    logic [PW-1:0]          mark_reg, mark_next;
    logic                   virt_reg, virt_next;
    logic [AW-1:0]          n_reg, n_next;
    logic [PW-1:0]          cur_reg, cur_next;
    logic [AW-1:0]          prev_reg, prev_next;
    logic [PW-1:0]          idx_reg, idx_next;

    logic                   rsp_valid_reg, rsp_valid_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic                   pop_act_reg, pop_act_next;
    logic [ACTOR_BITS-1:0]  pop_actor_reg, pop_actor_next;
    logic [EFFECT_BITS-1:0] pop_eff_reg, pop_eff_next;
    logic [TIME_BITS-1:0]   pop_time_reg, pop_time_next;

    // RAM ports.
    logic [AW-1:0]        rd_addr;
    logic                 t_we;
    logic [AW-1:0]        t_waddr;
    logic [TIME_BITS-1:0] t_wdata, time_rd;
    logic                 nx_we;
    logic [AW-1:0]        nx_waddr;
    logic [PW-1:0]        nx_wdata, next_rd;
    logic                 p_we;
    logic [PLW-1:0]       p_wdata, pl_rd;
    logic                 s_we;
    logic [AW-1:0]        s_waddr, s_wdata, s_raddr, s_rd;

    // Helper terms.
    logic                   accept;
    logic                   head_empty;
    logic [PW-1:0]          eff_count, eff_mark, pop_pos;
    logic [TIME_BITS:0]     sum;
    logic [TIME_BITS-1:0]   t_sat, reb_time;
    logic [PW-1:0]          virt_slot;
    logic [AW-1:0]          alloc_slot;
    logic                   rd_is_actor, match, next_nil, time_gt, push_ok, ins_actor;
    logic [ACTOR_BITS-1:0]  rd_actor;
    logic [EFFECT_BITS-1:0] rd_eff;
    logic [PW-1:0]          idx_prev;

    assign accept     = req.valid && req.ready;
    assign head_empty = head_reg >= NIL;
    assign eff_count  = head_empty ? NIL : count_reg;
    assign eff_mark   = head_empty ? NIL : mark_reg;
    assign pop_pos    = eff_count - PW'(1);
    assign sum        = {1'b0, start_reg} + (TIME_BITS + 1)'(req.delay);
    assign t_sat      = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
    assign virt_slot  = LAST - count_reg;
    assign alloc_slot = virt_reg ? virt_slot[AW-1:0] : s_rd;
    assign rd_is_actor = pl_rd[PLW-1];
    assign rd_actor   = pl_rd[PLW-2 -: ACTOR_BITS];
    assign rd_eff     = pl_rd[EFFECT_BITS-1:0];
    assign match      = (func_reg == FN_REM_ACTOR) ? (rd_is_actor && rd_actor == actor_reg)
                      : (!rd_is_actor && rd_actor == actor_reg && rd_eff == effect_reg);
    assign next_nil   = next_rd >= NIL;
    assign time_gt    = time_rd > t_reg;
    assign reb_time   = (time_rd > start_reg) ? (time_rd - start_reg) : '0;
    assign push_ok    = count_reg < NIL;
    assign ins_actor  = func_reg == FN_INS_ACTOR;
    assign idx_prev   = idx_reg - PW'(1);

    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign cfg.ready = 1'b1;

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.popped_is_actor = pop_act_reg;
    assign rsp.popped_actor    = pop_actor_reg;
    assign rsp.popped_effect   = pop_eff_reg;
    assign rsp.popped_time     = pop_time_reg;

    // Slot memories and free-slot stack.
    teq_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOTS)) u_time_ram (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(rd_addr), .rdata(time_rd)
    );
    teq_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_next_ram (
        .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(rd_addr), .rdata(next_rd)
    );
    teq_ram #(.WIDTH(PLW), .DEPTH(SLOTS)) u_payload_ram (
        .clk(clk), .we(p_we), .waddr(n_next), .wdata(p_wdata),
        .raddr(rd_addr), .rdata(pl_rd)
    );
    teq_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_stack_ram (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rd)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if ((req.func == FN_INS_ACTOR) || (req.func == FN_INS_EFFECT))
                        state_next = (eff_count == '0) ? S_IDLE : S_ALLOC;
                    else if ((req.func == FN_REM_ACTOR) || (req.func == FN_REM_EFFECT))
                        state_next = head_empty ? S_IDLE : S_RHEAD;
                    else if (req.func == FN_POP)
                        state_next = head_empty ? S_IDLE : S_POP;
                    else
                        state_next = S_IDLE;
                end
            end
            S_ALLOC:  state_next = head_empty ? S_IDLE : S_IHEAD;
            S_IHEAD:  state_next = time_gt ? S_IDLE : (next_nil ? S_LINK1 : S_IWALK);
            S_IWALK:  state_next = (time_gt || next_nil) ? S_LINK1 : S_IWALK;
            S_LINK1:  state_next = S_LINK2;
            S_LINK2:  state_next = S_IDLE;
            S_RHEAD,
            S_RWALK:  state_next = (match || next_nil) ? S_IDLE : S_RWALK;
            S_POP:    state_next = (time_rd > thr_reg) ? S_REBASE : S_IDLE;
            S_REBASE: state_next = (idx_reg == NIL) ? S_IDLE : S_REBASE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath, RAM control and response register.
    always_comb
    begin
        func_next      = func_reg;
        actor_next     = actor_reg;
        effect_next    = effect_reg;
        t_next         = t_reg;
        start_next     = start_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        mark_next      = mark_reg;
        virt_next      = virt_reg;
        n_next         = n_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        idx_next       = idx_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        pop_act_next   = pop_act_reg;
        pop_actor_next = pop_actor_reg;
        pop_eff_next   = pop_eff_reg;
        pop_time_next  = pop_time_reg;
        rd_addr        = head_reg[AW-1:0];
        t_we           = 1'b0;
        t_waddr        = n_reg;
        t_wdata        = t_reg;
        nx_we          = 1'b0;
        nx_waddr       = n_reg;
        nx_wdata       = NIL;
        p_we           = 1'b0;
        p_wdata        = {ins_actor, actor_reg, ins_actor ? EFFECT_BITS'(0) : effect_reg};
        s_we           = 1'b0;
        s_waddr        = count_reg[AW-1:0];
        s_wdata        = cur_reg[AW-1:0];
        s_raddr        = pop_pos[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next      = req.func;
                    actor_next     = req.actor_id;
                    effect_next    = req.effect_id;
                    status_next    = ST_OK;
                    pop_act_next   = 1'b0;
                    pop_actor_next = '0;
                    pop_eff_next   = '0;
                    pop_time_next  = '0;
                    cur_next       = head_reg;
                    priority if ((req.func == FN_INS_ACTOR) || (req.func == FN_INS_EFFECT))
                    begin
                        // Time from the old start time; an empty queue refills the stack.
                        t_next = t_sat;
                        if (head_empty)
                        begin
                            start_next = '0;
                        end
                        if (eff_count == '0)
                        begin
                            status_next    = ST_FULL;
                            rsp_valid_next = 1'b1;
                        end
                        else
                        begin
                            count_next = pop_pos;
                            virt_next  = eff_mark > pop_pos;
                            mark_next  = (eff_mark > pop_pos) ? pop_pos : eff_mark;
                        end
                    end
                    else if ((req.func == FN_REM_ACTOR) || (req.func == FN_REM_EFFECT) ||
                             (req.func == FN_POP))
                    begin
                        if (head_empty)
                        begin
                            status_next    = ST_EMPTY;
                            rsp_valid_next = 1'b1;
                        end
                    end
                    else
                    begin
                        rsp_valid_next = 1'b1;
                    end
                end
            end
            S_ALLOC:
            begin
                // Write the new entry into the slot taken off the stack.
                n_next  = alloc_slot;
                t_we    = 1'b1;
                t_waddr = alloc_slot;
                p_we    = 1'b1;
                if (head_empty)
                begin
                    nx_we          = 1'b1;
                    nx_waddr       = alloc_slot;
                    nx_wdata       = NIL;
                    head_next      = PW'(alloc_slot);
                    rsp_valid_next = 1'b1;
                end
            end
            S_IHEAD:
            begin
                if (time_gt)
                begin
                    nx_we          = 1'b1;
                    nx_wdata       = cur_reg;
                    head_next      = PW'(n_reg);
                    rsp_valid_next = 1'b1;
                end
                else
                begin
                    prev_next = cur_reg[AW-1:0];
                    cur_next  = next_rd;
                    rd_addr   = next_rd[AW-1:0];
                end
            end
            S_IWALK:
            begin
                // Pass entries whose time is not later than the new one.
                if (!time_gt)
                begin
                    prev_next = cur_reg[AW-1:0];
                    cur_next  = next_rd;
                    rd_addr   = next_rd[AW-1:0];
                end
            end
            S_LINK1:
            begin
                nx_we    = 1'b1;
                nx_waddr = prev_reg;
                nx_wdata = PW'(n_reg);
            end
            S_LINK2:
            begin
                nx_we          = 1'b1;
                nx_wdata       = cur_reg;
                rsp_valid_next = 1'b1;
            end
            S_RHEAD,
            S_RWALK:
            begin
                if (match)
                begin
                    // Unlink the entry and push its slot back on the stack.
                    if (state_reg == S_RHEAD)
                    begin
                        head_next = next_rd;
                    end
                    else
                    begin
                        nx_we    = 1'b1;
                        nx_waddr = prev_reg;
                        nx_wdata = next_rd;
                    end
                    if (push_ok)
                    begin
                        s_we       = 1'b1;
                        count_next = count_reg + PW'(1);
                    end
                    rsp_valid_next = 1'b1;
                end
                else
                begin
                    prev_next = cur_reg[AW-1:0];
                    cur_next  = next_rd;
                    rd_addr   = next_rd[AW-1:0];
                    if (next_nil)
                    begin
                        status_next    = ST_NOT_FOUND;
                        rsp_valid_next = 1'b1;
                    end
                end
            end
            S_POP:
            begin
                pop_act_next   = rd_is_actor;
                pop_actor_next = rd_actor;
                pop_eff_next   = rd_eff;
                start_next     = time_rd;
                head_next      = next_rd;
                idx_next       = '0;
                if (push_ok)
                begin
                    s_we       = 1'b1;
                    count_next = count_reg + PW'(1);
                end
                if (time_rd > thr_reg)
                begin
                    pop_time_next = '0;
                end
                else
                begin
                    pop_time_next  = time_rd;
                    rsp_valid_next = 1'b1;
                end
            end
            S_REBASE:
            begin
                // Read slot idx while writing back the rebased time of the one before.
                rd_addr  = idx_reg[AW-1:0];
                idx_next = idx_reg + PW'(1);
                if (idx_reg != '0)
                begin
                    t_we    = 1'b1;
                    t_waddr = idx_prev[AW-1:0];
                    t_wdata = reb_time;
                end
                if (idx_reg == NIL)
                begin
                    start_next     = '0;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NIL;
            count_reg     <= NIL;
            mark_reg      <= NIL;
            start_reg     <= '0;
            thr_reg       <= THRESHOLD_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            mark_reg      <= mark_next;
            start_reg     <= start_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                thr_reg <= cfg.data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        actor_reg     <= actor_next;
        effect_reg    <= effect_next;
        t_reg         <= t_next;
        virt_reg      <= virt_next;
        n_reg         <= n_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        idx_reg       <= idx_next;
        status_reg    <= status_next;
        pop_act_reg   <= pop_act_next;
        pop_actor_reg <= pop_actor_next;
        pop_eff_reg   <= pop_eff_next;
        pop_time_reg  <= pop_time_next;
    end

    // A response is only shown once the sequencer has finished its transaction.
    assert property (@(posedge clk) disable iff (!rst_n) rsp.valid |-> state_reg == S_IDLE)
        else $error("response valid while sequencer busy");

    // The free count never exceeds the number of slots.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= NIL)
        else $error("free count out of range");

    // The head pointer is a slot or the empty mark.
    assert property (@(posedge clk) disable iff (!rst_n) head_reg <= NIL)
        else $error("head pointer out of range");

    // After a request is taken the block is busy until its response is delivered.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> !req.ready)
        else $error("request taken while previous one pending");

endmodule

[src/teq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module teq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[test/tb.sv]
// Self-checking testbench for the time-ordered event queue.
// Holds a predictor of the linked slot list, drives requests and threshold writes, and checks
// every response. Depends on teq_pkg, teq_if and time_ordered_event_queue_top.
module tb;
    import teq_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    localparam int NIL   = NSLOT;

    typedef struct packed {
        logic [STATUS_BITS-1:0]     status;
        logic                       is_actor;
        logic [ACTOR_BITS_DEF-1:0]  actor;
        logic [EFFECT_BITS_DEF-1:0] effect;
        logic [TIME_BITS-1:0]       due;
    } reply_t;

    logic clk;
    logic rst_n;

    teq_req_if req ();
    teq_rsp_if rsp ();
    teq_cfg_if cfg ();

    time_ordered_event_queue_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // Predictor state: a mirror of the slot memory, free stack and timing registers.
    logic [TIME_BITS-1:0]       q_time [NSLOT];
    int                         q_next [NSLOT];
    logic                       q_is_actor [NSLOT];
    logic [ACTOR_BITS_DEF-1:0]  q_actor [NSLOT];
    logic [EFFECT_BITS_DEF-1:0] q_effect [NSLOT];
    int                         free_slots [NSLOT];
    int                         free_cnt;
    int                         head;
    logic [TIME_BITS-1:0]       now_time;
    logic [TIME_BITS-1:0]       threshold;
    int                         live_cnt;

    reply_t expected_replies [$];
    int     error_count;
    bit     rsp_stall_en;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Timeout guard sized well beyond the slowest correct run.
    initial
    begin
        #80000000;
        $display("Verification failed");
        $finish;
    end

    function automatic void refill_free();
        for (int i = 0; i < NSLOT; i++)
            free_slots[i] = NSLOT - 1 - i;
        free_cnt = NSLOT;
    endfunction

    function automatic void release_slot(int n);
        if (free_cnt < NSLOT)
        begin
            free_slots[free_cnt] = n;
            free_cnt++;
        end
    endfunction

    function automatic bit entry_matches(int n, bit want_actor, logic [7:0] a, logic [5:0] e);
        if (want_actor)
            return q_is_actor[n] && q_actor[n] == a;
        return !q_is_actor[n] && q_actor[n] == a && q_effect[n] == e;
    endfunction

    // Works out the response to one request and advances the mirror.
    function automatic reply_t predict_reply(logic [2:0] fn, logic [7:0] a, logic [5:0] e,
                                             logic [15:0] dly);
        reply_t r;
        logic [31:0] sum;
        int n, prev, cur;
        bit want_actor;
        r = '0;
        want_actor = (fn == FN_REM_ACTOR);
        case (fn)
            FN_INS_ACTOR, FN_INS_EFFECT:
            begin
                sum = {1'b0, now_time} + 32'(dly);
                if (sum > {1'b0, TIME_MAX})
                    sum = {1'b0, TIME_MAX};
                if (head == NIL)
                begin
                    refill_free();
                    now_time = '0;
                end
                if (free_cnt == 0)
                    r.status = ST_FULL;
                else
                begin
                    free_cnt--;
                    n = free_slots[free_cnt];
                    q_time[n] = sum[TIME_BITS-1:0];
                    q_is_actor[n] = (fn == FN_INS_ACTOR);
                    q_actor[n] = a;
                    q_effect[n] = (fn == FN_INS_ACTOR) ? '0 : e;
                    live_cnt++;
                    if (head == NIL)
                    begin
                        q_next[n] = NIL;
                        head = n;
                    end
                    else if (q_time[head] > q_time[n])
                    begin
                        q_next[n] = head;
                        head = n;
                    end
                    else
                    begin
                        prev = head;
                        cur = q_next[head];
                        while (cur != NIL && q_time[cur] <= q_time[n])
                        begin
                            prev = cur;
                            cur = q_next[cur];
                        end
                        q_next[prev] = n;
                        q_next[n] = cur;
                    end
                end
            end
            FN_REM_ACTOR, FN_REM_EFFECT:
            begin
                if (head == NIL)
                    r.status = ST_EMPTY;
                else if (entry_matches(head, want_actor, a, e))
                begin
                    n = head;
                    head = q_next[n];
                    release_slot(n);
                    live_cnt--;
                end
                else
                begin
                    r.status = ST_NOT_FOUND;
                    prev = head;
                    cur = q_next[head];
                    while (cur != NIL)
                    begin
                        if (entry_matches(cur, want_actor, a, e))
                        begin
                            q_next[prev] = q_next[cur];
                            release_slot(cur);
                            live_cnt--;
                            r.status = ST_OK;
                            break;
                        end
                        prev = cur;
                        cur = q_next[cur];
                    end
                end
            end
            FN_POP:
            begin
                if (head == NIL)
                    r.status = ST_EMPTY;
                else
                begin
                    n = head;
                    now_time = q_time[n];
                    // Rebase every slot once the start time passes the threshold.
                    if (now_time > threshold)
                    begin
                        for (int i = 0; i < NSLOT; i++)
                            q_time[i] = (q_time[i] > now_time) ? q_time[i] - now_time : '0;
                        now_time = '0;
                    end
                    head = q_next[n];
                    release_slot(n);
                    live_cnt--;
                    r.is_actor = q_is_actor[n];
                    r.actor = q_actor[n];
                    r.effect = q_effect[n];
                    r.due = q_time[n];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Sends one request transaction, sometimes after a random burst gap.
    task automatic send_request(logic [2:0] fn, logic [7:0] a, logic [5:0] e, logic [15:0] dly);
        int gap;
        if ($urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.func <= fn;
        req.actor_id <= a;
        req.effect_id <= e;
        req.delay <= dly;
        expected_replies.insert(expected_replies.size(), predict_reply(fn, a, e, dly));
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_replies();
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Threshold writes only happen with all replies drained and the queue idle.
    task automatic write_threshold(logic [TIME_BITS-1:0] value);
        drain_replies();
        cfg.valid <= 1'b1;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        threshold = value;
    endtask

    // Random item biased towards inserts while the list is short.
    task automatic send_random(int ins_weight);
        logic [2:0] fn;
        int pick;
        logic [7:0] a;
        logic [5:0] e;
        pick = $urandom_range(0, 99);
        if (pick < ins_weight)
            fn = $urandom_range(0, 1) ? FN_INS_ACTOR : FN_INS_EFFECT;
        else if (pick < ins_weight + 20)
            fn = $urandom_range(0, 1) ? FN_REM_ACTOR : FN_REM_EFFECT;
        else if (pick < 98)
            fn = FN_POP;
        else
            fn = 3'($urandom_range(5, 7));
        // Small identifier range so removals find matches; full range now and then.
        a = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
        e = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 3));
        send_request(fn, a, e, $urandom_range(0, 2) == 0 ? 16'($urandom_range(0, 65535))
                                                         : 16'($urandom_range(0, 40)));
    endtask

    task automatic test_directed();
        send_request(FN_POP, 8'd0, 6'd0, 16'd0);
        send_request(FN_REM_ACTOR, 8'd1, 6'd0, 16'd0);
        send_request(FN_REM_EFFECT, 8'd1, 6'd1, 16'd0);
        send_request(FN_INS_ACTOR, 8'd255, 6'd63, 16'd65535);
        send_request(FN_INS_EFFECT, 8'd0, 6'd63, 16'd0);
        send_request(FN_INS_EFFECT, 8'd255, 6'd0, 16'd0);
        send_request(FN_INS_ACTOR, 8'd7, 6'd0, 16'd0);
        send_request(FN_REM_ACTOR, 8'd99, 6'd0, 16'd0);
        send_request(FN_REM_EFFECT, 8'd0, 6'd1, 16'd0);
        send_request(FN_REM_EFFECT, 8'd255, 6'd0, 16'd0);
        send_request(FN_REM_ACTOR, 8'd7, 6'd0, 16'd0);
        send_request(3'd5, 8'd1, 6'd1, 16'd1);
        send_request(3'd7, 8'd2, 6'd2, 16'd2);
        send_request(FN_POP, 8'd0, 6'd0, 16'd0);
        send_request(FN_POP, 8'd0, 6'd0, 16'd0);
        send_request(FN_POP, 8'd0, 6'd0, 16'd0);
    endtask

    // Fill every slot, overflow once, then empty the queue again.
    task automatic test_full();
        for (int i = 0; i <= NSLOT; i++)
            send_request(i[0] ? FN_INS_EFFECT : FN_INS_ACTOR, i[7:0], i[5:0],
                         16'($urandom_range(0, 9)));
        send_request(FN_REM_ACTOR, 8'd200, 6'd0, 16'd0);
        for (int i = 0; i < NSLOT; i++)
            send_request(FN_POP, 8'd0, 6'd0, 16'd0);
    endtask

    // Low thresholds force rebases; long delay chains push the start time upwards.
    task automatic test_rebase();
        write_threshold(31'd1);
        for (int i = 0; i < 150; i++)
            send_random(live_cnt < 8 ? 60 : 35);
        write_threshold(31'd100);
        for (int i = 0; i < 150; i++)
            send_random(live_cnt < 8 ? 60 : 35);
        write_threshold(TIME_MAX);
        // Climb upwards: keep one entry and pop far-future ones.
        send_request(FN_INS_ACTOR, 8'd1, 6'd0, 16'd0);
        for (int i = 0; i < 100; i++)
        begin
            send_request(FN_INS_EFFECT, 8'd2, 6'd3, 16'd65535);
            send_request(FN_POP, 8'd0, 6'd0, 16'd0);
            if (now_time == TIME_MAX)
                break;
        end
        send_request(FN_INS_ACTOR, 8'd3, 6'd0, 16'd65535);
        send_request(FN_POP, 8'd0, 6'd0, 16'd0);
        while (live_cnt > 0)
            send_request(FN_POP, 8'd0, 6'd0, 16'd0);
    endtask

    task automatic test_random();
        write_threshold(31'd5000);
        for (int i = 0; i < 650; i++)
            send_random(live_cnt < 20 ? 55 : 35);
        // Hold the sender until the queue has answered everything.
        drain_replies();
        write_threshold(THRESHOLD_RESET);
        for (int i = 0; i < 550; i++)
            send_random(live_cnt < 40 ? 50 : 30);
    endtask

    // Response checker: compares each response transaction with the oldest expectation.
    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rsp.valid && rsp.ready)
        begin
            got = '{rsp.status, rsp.popped_is_actor, rsp.popped_actor, rsp.popped_effect,
                    rsp.popped_time};
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected response %p", $time, got);
                error_count++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall pattern: long open stretches alternating with random stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_stall_en <= 1'b1;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                rsp_stall_en <= ~rsp_stall_en;
            rsp.ready <= rsp_stall_en ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    initial
    begin
        error_count = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            q_time[i] = '0;
            q_next[i] = 0;
            q_is_actor[i] = 1'b0;
            q_actor[i] = '0;
            q_effect[i] = '0;
        end
        refill_free();
        head = NIL;
        now_time = '0;
        threshold = THRESHOLD_RESET;
        live_cnt = 0;
        req.valid = 1'b0;
        req.func = '0;
        req.actor_id = '0;
        req.effect_id = '0;
        req.delay = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full();
        test_random();
        test_rebase();

        drain_replies();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[time_ordered_event_queue_top.f]
src/teq_pkg.sv
src/teq_if.sv
src/teq_ram.sv
src/time_ordered_event_queue_top.sv
test/tb.sv
